// ===== design/shfd_pkg.sv =====
package shfd_pkg;

  localparam int ByteW   = 8;
  localparam int CountW  = 14;
  localparam int EventW  = 3;
  localparam int OffW    = 4;
  localparam int LengthW = 32;

  // Result event codes.
  localparam logic [EventW-1:0] EV_DROP    = 3'd0;
  localparam logic [EventW-1:0] EV_PAYLOAD = 3'd1;
  localparam logic [EventW-1:0] EV_ACCEPT  = 3'd2;
  localparam logic [EventW-1:0] EV_REJECT  = 3'd3;
  localparam logic [EventW-1:0] EV_RESTART = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_START_CHAR    = 2'd0;
  localparam logic [1:0] REG_END_CHAR      = 2'd1;
  localparam logic [1:0] REG_MIN_LENGTH    = 2'd2;
  localparam logic [1:0] REG_LENGTH_OFFSET = 2'd3;

  localparam logic [CountW-1:0] COUNT_SAT  = 14'd10000;
  localparam logic [CountW-1:0] LENGTH_MAX = 14'd9999;
  localparam logic [OffW:0]     DIGITS     = 5'd4;

  localparam logic [ByteW-1:0]  START_RESET  = 8'd42;
  localparam logic [ByteW-1:0]  END_RESET    = 8'd35;
  localparam logic [CountW-1:0] MIN_RESET    = 14'd10;
  localparam logic [OffW-1:0]   OFFSET_RESET = 4'd6;

  localparam logic [ByteW-1:0] ASCII_ZERO = 8'h30;
  localparam logic [ByteW-1:0] ASCII_NINE = 8'h39;

  typedef struct packed {
    logic [ByteW-1:0]  start_char;
    logic [ByteW-1:0]  end_char;
    logic [CountW-1:0] min_length;
    logic [OffW-1:0]   length_offset;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic [EventW-1:0] event_res;
    logic [CountW-1:0] frame_count;
  } result_t;

endpackage

// ===== design/star_hash_frame_deframer_top.sv =====
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid / in_stall    | in_byte
// output  | out       | out_valid / out_stall  | out_byte, event_res, frame_count
// config  | in        | APB psel/penable/pready| paddr, pwdata, prdata
//
// One byte is taken per cycle while in_stall is low; its result is registered in the
// output register, or in the skid register while the output is stalled.
// The frame state and decision logic sit in one combinational step ahead of that register.
// Reset is synchronous and active high; it restores config, frame state and valid flags.
// A skid register catches one result while out_stall is high; in_stall rises only
// once both the output and skid registers are full.
module star_hash_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [shfd_pkg::ByteW-1:0]    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [shfd_pkg::ByteW-1:0]    out_byte,
  output logic [shfd_pkg::EventW-1:0]   event_res,
  output logic [shfd_pkg::CountW-1:0]   frame_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  shfd_pkg::cfg_t    cfg;
  shfd_pkg::result_t new_res;
  shfd_pkg::result_t out_res;
  shfd_pkg::result_t skid_res;
  logic              skid_valid;
  logic              take;
  logic              out_free;

  assign in_stall = skid_valid;
  assign take     = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  shfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shfd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (in_byte),
    .cfg     (cfg),
    .res     (new_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : new_res;
    end else if (take) begin
      skid_res <= new_res;
    end
  end

  assign out_byte    = out_res.out_byte;
  assign event_res   = out_res.event_res;
  assign frame_count = out_res.frame_count;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall && in_valid))
    else $error("skid register filled without a stalled output");

  a_out_after_take: assert property (@(posedge clk) disable iff (rst)
    (take && !out_valid) |=> out_valid)
    else $error("accepted transaction did not reach the output register");

endmodule

// ===== design/shfd_cfg.sv =====
module shfd_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output shfd_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_char    <= shfd_pkg::START_RESET;
      cfg.end_char      <= shfd_pkg::END_RESET;
      cfg.min_length    <= shfd_pkg::MIN_RESET;
      cfg.length_offset <= shfd_pkg::OFFSET_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        shfd_pkg::REG_START_CHAR:    cfg.start_char    <= pwdata[shfd_pkg::ByteW-1:0];
        shfd_pkg::REG_END_CHAR:      cfg.end_char      <= pwdata[shfd_pkg::ByteW-1:0];
        shfd_pkg::REG_MIN_LENGTH:    cfg.min_length    <= pwdata[shfd_pkg::CountW-1:0];
        shfd_pkg::REG_LENGTH_OFFSET: cfg.length_offset <= pwdata[shfd_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      shfd_pkg::REG_START_CHAR:    prdata = {24'd0, cfg.start_char};
      shfd_pkg::REG_END_CHAR:      prdata = {24'd0, cfg.end_char};
      shfd_pkg::REG_MIN_LENGTH:    prdata = {18'd0, cfg.min_length};
      shfd_pkg::REG_LENGTH_OFFSET: prdata = {28'd0, cfg.length_offset};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/shfd_core.sv =====
module shfd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [shfd_pkg::ByteW-1:0]    in_byte,
  input  shfd_pkg::cfg_t                cfg,
  output shfd_pkg::result_t             res
);

  logic                          in_frame;
  logic [shfd_pkg::CountW-1:0]   byte_count;
  logic [shfd_pkg::LengthW-1:0]  length_value;
  logic                          digits_valid;

  logic                          in_frame_next;
  logic [shfd_pkg::CountW-1:0]   byte_count_next;
  logic [shfd_pkg::LengthW-1:0]  length_value_next;
  logic                          digits_valid_next;

  logic                          is_start;
  logic                          is_end;
  logic                          is_digit;
  logic [3:0]                    digit;
  logic [shfd_pkg::OffW:0]       digit_end;
  logic                          at_digit_pos;
  logic                          frame_ok;
  logic [shfd_pkg::CountW-1:0]   count_inc;
  logic [shfd_pkg::LengthW-1:0]  length_acc;

  assign is_start  = (in_byte == cfg.start_char);
  assign is_end    = (in_byte == cfg.end_char);
  assign is_digit  = (in_byte >= shfd_pkg::ASCII_ZERO) && (in_byte <= shfd_pkg::ASCII_NINE);
  assign digit     = in_byte[3:0];
  assign digit_end = {1'b0, cfg.length_offset} + shfd_pkg::DIGITS;

  assign at_digit_pos = (byte_count >= {10'd0, cfg.length_offset}) &&
                        (byte_count < {9'd0, digit_end});

  // Times ten as two shifts. A length offset moved inside an open frame can
  // add more digit positions, so the value keeps the full word and wraps there.
  assign length_acc = (length_value << 3) + (length_value << 1) + {28'd0, digit};

  assign count_inc = (byte_count < shfd_pkg::COUNT_SAT) ? byte_count + 14'd1 : byte_count;

  assign frame_ok = (byte_count != '0) &&
                    (byte_count >= cfg.min_length) &&
                    (byte_count >= {9'd0, digit_end}) &&
                    digits_valid &&
                    (length_value == {18'd0, byte_count});

  always_comb begin
    in_frame_next     = in_frame;
    byte_count_next   = byte_count;
    length_value_next = length_value;
    digits_valid_next = digits_valid;
    res.out_byte      = '0;
    res.event_res     = shfd_pkg::EV_DROP;
    res.frame_count   = '0;
    priority if (!in_frame) begin
      if (is_start) begin
        in_frame_next     = 1'b1;
        byte_count_next   = '0;
        length_value_next = '0;
        digits_valid_next = 1'b1;
      end
    end else if (is_end) begin
      // The end test comes first so equal start and end characters close.
      in_frame_next     = 1'b0;
      byte_count_next   = '0;
      length_value_next = '0;
      digits_valid_next = 1'b1;
      res.event_res     = frame_ok ? shfd_pkg::EV_ACCEPT : shfd_pkg::EV_REJECT;
      res.frame_count   = byte_count;
    end else if (is_start) begin
      byte_count_next   = '0;
      length_value_next = '0;
      digits_valid_next = 1'b1;
      res.event_res     = shfd_pkg::EV_RESTART;
    end else begin
      if (at_digit_pos) begin
        if (is_digit) begin
          length_value_next = length_acc;
        end else begin
          digits_valid_next = 1'b0;
        end
      end
      byte_count_next = count_inc;
      res.out_byte    = in_byte;
      res.event_res   = shfd_pkg::EV_PAYLOAD;
      res.frame_count = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      byte_count   <= '0;
      length_value <= '0;
      digits_valid <= 1'b1;
    end else if (take) begin
      in_frame     <= in_frame_next;
      byte_count   <= byte_count_next;
      length_value <= length_value_next;
      digits_valid <= digits_valid_next;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    byte_count <= shfd_pkg::COUNT_SAT)
    else $error("byte count above saturation");

  a_length_hold: assert property (@(posedge clk) disable iff (rst)
    (take && in_frame && !is_end && !is_start && !at_digit_pos) |=> $stable(length_value))
    else $error("length value changed outside a length position");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (byte_count == '0 && length_value == '0 && digits_valid))
    else $error("frame state not cleared outside a frame");

endmodule

// ===== test/star_hash_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps

module star_hash_frame_deframer_top_tb;

  localparam int LONG_HOLD = 80;

  typedef logic [shfd_pkg::ByteW-1:0] byte_t;

  typedef struct {
    byte_t             in_byte;
    bit                typed;
    shfd_pkg::result_t res;
  } walk_row_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  byte_t                       in_byte;
  logic                        out_valid;
  logic                        out_stall;
  byte_t                       out_byte;
  logic [shfd_pkg::EventW-1:0] event_res;
  logic [shfd_pkg::CountW-1:0] frame_count;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [3:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  // Frame state tracked alongside the block.
  shfd_pkg::cfg_t               cfg;
  logic                         in_frame;
  logic [shfd_pkg::CountW-1:0]  byte_count;
  logic [shfd_pkg::LengthW-1:0] length_value;
  logic                         digits_valid;

  shfd_pkg::result_t frame_events_q[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  bit      tx_quiet = 1'b0;
  bit      rx_quiet = 1'b0;
  int      rx_window = 0;
  int      hold_id = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  // Opening, stray and empty-frame handling, restart, one good frame and one
  // frame that closes before its length digits.
  walk_row_t walk_rows [23] = '{
    '{shfd_pkg::END_RESET,   1'b1, '{8'h00, shfd_pkg::EV_DROP,    14'd0}},
    '{8'h00,                 1'b1, '{8'h00, shfd_pkg::EV_DROP,    14'd0}},
    '{8'hFF,                 1'b1, '{8'h00, shfd_pkg::EV_DROP,    14'd0}},
    '{shfd_pkg::START_RESET, 1'b1, '{8'h00, shfd_pkg::EV_DROP,    14'd0}},
    '{shfd_pkg::END_RESET,   1'b1, '{8'h00, shfd_pkg::EV_REJECT,  14'd0}},
    '{shfd_pkg::START_RESET, 1'b1, '{8'h00, shfd_pkg::EV_DROP,    14'd0}},
    '{8'h41,                 1'b1, '{8'h41, shfd_pkg::EV_PAYLOAD, 14'd1}},
    '{shfd_pkg::START_RESET, 1'b1, '{8'h00, shfd_pkg::EV_RESTART, 14'd0}},
    '{8'h00,                 1'b0, '0},
    '{8'hFF,                 1'b0, '0},
    '{8'h51,                 1'b0, '0},
    '{8'h80,                 1'b0, '0},
    '{8'h7F,                 1'b0, '0},
    '{8'h7A,                 1'b0, '0},
    '{8'h30,                 1'b0, '0},
    '{8'h30,                 1'b0, '0},
    '{8'h31,                 1'b0, '0},
    '{8'h30,                 1'b0, '0},
    '{shfd_pkg::END_RESET,   1'b1, '{8'h00, shfd_pkg::EV_ACCEPT,  14'd10}},
    '{shfd_pkg::START_RESET, 1'b1, '{8'h00, shfd_pkg::EV_DROP,    14'd0}},
    '{8'h61,                 1'b0, '0},
    '{8'h62,                 1'b0, '0},
    '{shfd_pkg::END_RESET,   1'b1, '{8'h00, shfd_pkg::EV_REJECT,  14'd2}}
  };

  star_hash_frame_deframer_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .event_res   (event_res),
    .frame_count (frame_count),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_frame_state();
    byte_count   = '0;
    length_value = '0;
    digits_valid = 1'b1;
  endfunction

  function automatic shfd_pkg::result_t deframe_byte(input byte_t b);
    shfd_pkg::result_t r;
    int                first_digit;
    r = '0;
    first_digit = int'(cfg.length_offset);
    if (!in_frame) begin
      if (b == cfg.start_char) begin
        in_frame = 1'b1;
        clear_frame_state();
      end
      r.event_res = shfd_pkg::EV_DROP;
    end else if (b == cfg.end_char) begin
      // The end test comes first, so equal start and end characters close.
      r.frame_count = byte_count;
      r.event_res = (byte_count != 0 && byte_count >= cfg.min_length &&
                     int'(byte_count) >= first_digit + int'(shfd_pkg::DIGITS) &&
                     digits_valid && length_value == {18'd0, byte_count}) ?
                    shfd_pkg::EV_ACCEPT : shfd_pkg::EV_REJECT;
      in_frame = 1'b0;
      clear_frame_state();
    end else if (b == cfg.start_char) begin
      clear_frame_state();
      r.event_res = shfd_pkg::EV_RESTART;
    end else begin
      if (int'(byte_count) >= first_digit &&
          int'(byte_count) < first_digit + int'(shfd_pkg::DIGITS)) begin
        if (b >= shfd_pkg::ASCII_ZERO && b <= shfd_pkg::ASCII_NINE) begin
          length_value = length_value * 32'd10 + 32'(b - shfd_pkg::ASCII_ZERO);
        end else begin
          digits_valid = 1'b0;
        end
      end
      if (byte_count < shfd_pkg::COUNT_SAT) begin
        byte_count = byte_count + 1'b1;
      end
      r.out_byte    = b;
      r.event_res   = shfd_pkg::EV_PAYLOAD;
      r.frame_count = byte_count;
    end
    return r;
  endfunction

  function automatic byte_t body_byte();
    byte_t b;
    do begin
      b = byte_t'($urandom_range(0, 255));
    end while (b == cfg.start_char || b == cfg.end_char);
    return b;
  endfunction

  function automatic byte_t bad_digit();
    byte_t b;
    do begin
      b = byte_t'($urandom_range(0, 255));
    end while ((b >= shfd_pkg::ASCII_ZERO && b <= shfd_pkg::ASCII_NINE) ||
               b == cfg.start_char || b == cfg.end_char);
    return b;
  endfunction

  function automatic byte_t noise_byte();
    byte_t b;
    if ($urandom_range(0, 3) == 0) begin
      return cfg.end_char;
    end
    do begin
      b = byte_t'($urandom_range(0, 255));
    end while (b == cfg.start_char);
    return b;
  endfunction

  // Offers one byte and records the result it must produce once it is taken.
  task automatic send_byte(input byte_t b, input bit typed, input shfd_pkg::result_t want);
    shfd_pkg::result_t r;
    while (!tx_quiet && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_byte  <= b;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (in_stall);
    items_sent++;
    r = deframe_byte(b);
    frame_events_q.push_back(typed ? want : r);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (frame_events_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      shfd_pkg::REG_START_CHAR:    cfg.start_char    = val[shfd_pkg::ByteW-1:0];
      shfd_pkg::REG_END_CHAR:      cfg.end_char      = val[shfd_pkg::ByteW-1:0];
      shfd_pkg::REG_MIN_LENGTH:    cfg.min_length    = val[shfd_pkg::CountW-1:0];
      shfd_pkg::REG_LENGTH_OFFSET: cfg.length_offset = val[shfd_pkg::OffW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input int s, input int e, input int m, input int o,
                               input int tx_pct, input int rx_pct);
    write_reg(shfd_pkg::REG_START_CHAR, 32'(s));
    write_reg(shfd_pkg::REG_END_CHAR, 32'(e));
    write_reg(shfd_pkg::REG_MIN_LENGTH, 32'(m));
    write_reg(shfd_pkg::REG_LENGTH_OFFSET, 32'(o));
    send_idle_pct = tx_pct;
    stall_pct     = rx_pct;
  endtask

  // Half are well-formed frames with a correct length field; the rest carry a
  // wrong length, a non-digit, a restart, stray bytes or too few bytes.
  task automatic send_frame();
    int    kind, n, len_val, off, lo, cut, bad_pos, pw, i;
    byte_t b;
    kind     = $urandom_range(0, 9);
    off      = int'(cfg.length_offset);
    lo       = (int'(cfg.min_length) > off + 4) ? int'(cfg.min_length) : off + 4;
    tx_quiet = ($urandom_range(0, 3) == 0);
    if (kind == 8) begin
      repeat ($urandom_range(1, 6)) send_byte(noise_byte(), 1'b0, '0);
      return;
    end
    if (lo > 60) begin
      n = $urandom_range(off + 4, off + 20);
    end else begin
      n = lo + $urandom_range(0, 10);
    end
    if (kind == 9) begin
      n = $urandom_range(0, off + 3);
    end
    len_val = (kind == 5) ? (n + $urandom_range(1, 50)) % 10000 : n;
    bad_pos = (kind == 6) ? off + $urandom_range(0, 3) : -1;
    if (kind == 7) begin
      cut = $urandom_range(0, 12);
      send_byte(cfg.start_char, 1'b0, '0);
      repeat (cut) send_byte(body_byte(), 1'b0, '0);
    end
    send_byte(cfg.start_char, 1'b0, '0);
    for (i = 0; i < n; i++) begin
      if (i == bad_pos) begin
        b = bad_digit();
      end else if (i >= off && i < off + 4) begin
        pw = 1000;
        repeat (i - off) pw = pw / 10;
        b = shfd_pkg::ASCII_ZERO + byte_t'((len_val / pw) % 10);
      end else begin
        b = body_byte();
      end
      send_byte(b, 1'b0, '0);
    end
    send_byte(cfg.end_char, 1'b0, '0);
    tx_quiet = 1'b0;
  endtask

  task automatic random_frames(input int count);
    int mark;
    mark = items_sent;
    while (items_sent - mark < count) begin
      send_frame();
    end
  endtask

  // Receiver: random stalls, quiet windows, a long hold on request, and the check.
  always @(posedge clk) begin
    shfd_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_events_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result with nothing pending: byte %h event %0d count %0d",
                     $realtime, out_byte, event_res, frame_count);
          end
        end else begin
          want = frame_events_q.pop_front();
          if (out_byte !== want.out_byte || event_res !== want.event_res ||
              frame_count !== want.frame_count) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: mismatch: byte %h/%h event %0d/%0d count %0d/%0d (exp/act)",
                       $realtime, want.out_byte, out_byte, want.event_res, event_res,
                       want.frame_count, frame_count);
            end
          end
        end
      end
      if (hold_id != hold_seen) begin
        hold_seen <= hold_id;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(0, 99) < stall_pct);
      end
      if (rx_window == 0) begin
        rx_window <= 32;
        rx_quiet  <= ($urandom_range(0, 3) == 0);
      end else begin
        rx_window <= rx_window - 1;
      end
    end
  end

  initial begin
    int i;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    cfg       = '{shfd_pkg::START_RESET, shfd_pkg::END_RESET, shfd_pkg::MIN_RESET,
                  shfd_pkg::OFFSET_RESET};
    in_frame  = 1'b0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (walk_rows[k]) begin
      send_byte(walk_rows[k].in_byte, walk_rows[k].typed, walk_rows[k].res);
    end
    random_frames(200);
    wait_quiet();

    // Lowest start character and limits, highest end character; the receiver holds off long enough to
    // back the block up, and later the sender waits for everything to drain.
    apply_setting(8'h00, 8'hFF, 0, 0, 65, 0);
    random_frames(90);
    hold_id <= hold_id + 1;
    random_frames(60);
    wait_quiet();
    random_frames(70);
    wait_quiet();

    apply_setting(8'hFF, 8'h00, int'(shfd_pkg::LENGTH_MAX), 15, 0, 65);
    random_frames(200);
    wait_quiet();

    apply_setting(8'h55, 8'h55, 4, 3, 26, 26);
    random_frames(200);
    wait_quiet();

    // Largest length field in a frame far shorter than the minimum it sets.
    apply_setting(shfd_pkg::START_RESET, shfd_pkg::END_RESET,
                  int'(shfd_pkg::LENGTH_MAX), 0, 0, 0);
    send_byte(cfg.start_char, 1'b0, '0);
    for (i = 0; i < 9; i++) begin
      send_byte((i < 4) ? shfd_pkg::ASCII_NINE : body_byte(), 1'b0, '0);
    end
    send_byte(cfg.end_char, 1'b1, '{8'h00, shfd_pkg::EV_REJECT, 14'd9});
    wait_quiet();

    apply_setting(8'h7E, 8'h0A, 12, 15, 26, 26);
    random_frames(200);
    wait_quiet();

    repeat (10) @(posedge clk);
    fail_count += frame_events_q.size();
    if (fail_count == 0) begin
      $display("** star_hash_frame_deframer_top: PASSED **");
    end else begin
      $display("** star_hash_frame_deframer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("** star_hash_frame_deframer_top: FAILED **");
    $finish;
  end

endmodule
